/* sv/dthf_pkg.sv */
// ----------------------------------------------------------------------------
// dthf_pkg
// Shared types and constants for the double to hex float text formatter:
// controller states, character selects and the command/status words that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package dthf_pkg;

    // Default for the most fraction digits printed after the point
    localparam int MAX_DIGITS_DEF = 28;

    // Field geometry of an IEEE binary64 word
    localparam int FRAC_W = 52;
    localparam int BEXP_W = 11;
    localparam int E2_W   = 12;   // signed binary exponent, -1074 .. 1023
    localparam int MAG_W  = 11;   // |e2| up to 1074
    localparam int BCD_W  = 16;   // four decimal digits
    localparam int DCNT_W = 5;    // digit count field width
    localparam int CHAR_W = 7;

    localparam logic [BEXP_W-1:0] BEXP_SPECIAL = '1;
    localparam logic [E2_W-1:0]   EXP_BIAS     = 12'd1023;
    localparam logic [E2_W-1:0]   SUB_EXP      = 12'hC02;   // -1022

    // Double dabble runs one pass per magnitude bit
    localparam logic [3:0] CONV_LAST = 4'(MAG_W - 1);

    // ASCII codes
    localparam logic [CHAR_W-1:0] ASC_NUL   = 7'h00;
    localparam logic [CHAR_W-1:0] ASC_MINUS = 7'h2d;
    localparam logic [CHAR_W-1:0] ASC_PLUS  = 7'h2b;
    localparam logic [CHAR_W-1:0] ASC_POINT = 7'h2e;
    localparam logic [CHAR_W-1:0] ASC_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] ASC_ONE   = 7'h31;
    localparam logic [CHAR_W-1:0] ASC_LOW_A = 7'h61;
    localparam logic [CHAR_W-1:0] ASC_P     = 7'h70;
    localparam logic [CHAR_W-1:0] ASC_X     = 7'h78;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_NORM,
        ST_CONV,
        ST_MINUS,
        ST_ZERO,
        ST_X,
        ST_LEAD,
        ST_POINT,
        ST_FRAC,
        ST_P,
        ST_ESIGN,
        ST_EDIG,
        ST_NAN
    } state_t;

    typedef enum logic [3:0] {
        CH_NUL,
        CH_MINUS,
        CH_ZERO,
        CH_X,
        CH_LEAD,
        CH_POINT,
        CH_FRAC,
        CH_P,
        CH_ESIGN,
        CH_EDIG
    } char_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic      load;
        logic      norm_step;
        logic      conv_step;
        logic      emit;
        char_sel_t sel;
        logic      frac_step;
        logic      ed_init;
        logic      ed_step;
        logic      last;
        logic      nf;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic nan;
        logic neg_show;
        logic norm_done;
        logic conv_last;
        logic frac_none;
        logic frac_last;
        logic ed_zero;
        logic out_free;
    } sts_t;

endpackage

/* sv/dthf_dp.sv */
// ----------------------------------------------------------------------------
// dthf_dp
// Datapath: field decode, subnormal normalizer (one bit a cycle), exponent
// binary to BCD (double dabble, one bit a cycle), digit counters and the
// character output register.
// ----------------------------------------------------------------------------
module dthf_dp #(
    parameter int MAX_DIGITS = dthf_pkg::MAX_DIGITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dthf_pkg::cmd_t                cmd,
    output dthf_pkg::sts_t                sts,
    input  logic [63:0]                   value_bits,
    input  logic [dthf_pkg::DCNT_W-1:0]   digit_count,
    output logic                          char_valid,
    input  logic                          char_ready,
    output logic [dthf_pkg::CHAR_W-1:0]   char_code,
    output logic                          last_char,
    output logic                          not_finite
);
    import dthf_pkg::*;

    localparam logic [DCNT_W-1:0] MaxDig = DCNT_W'(MAX_DIGITS);

    // Operand registers
    logic [FRAC_W:0]        mant_reg, mant_next;
    logic signed [E2_W-1:0] e2_reg, e2_next;
    logic                   neg_reg, neg_next;
    logic                   zero_reg, zero_next;
    logic                   nan_reg, nan_next;
    logic [DCNT_W-1:0]      frac_left_reg, frac_left_next;
    logic [3:0]             conv_cnt_reg, conv_cnt_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [1:0]             ed_cnt_reg, ed_cnt_next;

    // Output register
    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      out_char_reg, out_char_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_nf_reg, out_nf_next;

    logic [BEXP_W-1:0]      in_bexp;
    logic [FRAC_W-1:0]      in_frac;
    logic [MAG_W-1:0]       mag;
    logic                   mag_bit;
    logic [BCD_W-1:0]       bcd_adj;
    logic [1:0]             ed_lead;
    logic [3:0]             frac_dig;
    logic [3:0]             exp_dig;
    logic [CHAR_W-1:0]      sel_char;
    logic                   out_free;

    assign in_bexp = value_bits[62:52];
    assign in_frac = value_bits[FRAC_W-1:0];

    // Exponent magnitude and the bit fed into the BCD shifter, MSB first
    always_comb
    begin
        logic [E2_W-1:0] neg_e2;
        neg_e2  = E2_W'(-e2_reg);
        mag     = e2_reg[E2_W-1] ? neg_e2[MAG_W-1:0] : e2_reg[MAG_W-1:0];
        mag_bit = mag[CONV_LAST - conv_cnt_reg];
    end

    // Double dabble add-3 correction on each nibble
    always_comb
    begin
        for (int k = 0; k < BCD_W / 4; k++)
        begin
            if (bcd_reg[4*k +: 4] >= 4'd5)
            begin
                bcd_adj[4*k +: 4] = bcd_reg[4*k +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*k +: 4] = bcd_reg[4*k +: 4];
            end
        end
    end

    // Position of the leading nonzero exponent digit (at least one digit)
    always_comb
    begin
        if (bcd_reg[15:12] != 4'd0)
        begin
            ed_lead = 2'd3;
        end
        else if (bcd_reg[11:8] != 4'd0)
        begin
            ed_lead = 2'd2;
        end
        else if (bcd_reg[7:4] != 4'd0)
        begin
            ed_lead = 2'd1;
        end
        else
        begin
            ed_lead = 2'd0;
        end
    end

    assign frac_dig = mant_reg[FRAC_W-1 -: 4];
    assign exp_dig  = bcd_reg[{ed_cnt_reg, 2'b00} +: 4];
    assign out_free = !out_valid_reg || char_ready;

    // Character mux
    always_comb
    begin
        unique case (cmd.sel)
            CH_MINUS: sel_char = ASC_MINUS;
            CH_ZERO:  sel_char = ASC_ZERO;
            CH_X:     sel_char = ASC_X;
            CH_LEAD:  sel_char = zero_reg ? ASC_ZERO : ASC_ONE;
            CH_POINT: sel_char = ASC_POINT;
            CH_FRAC:
            begin
                if (frac_dig < 4'd10)
                begin
                    sel_char = ASC_ZERO + CHAR_W'(frac_dig);
                end
                else
                begin
                    sel_char = ASC_LOW_A + CHAR_W'(frac_dig - 4'd10);
                end
            end
            CH_P:     sel_char = ASC_P;
            CH_ESIGN: sel_char = e2_reg[E2_W-1] ? ASC_MINUS : ASC_PLUS;
            CH_EDIG:  sel_char = ASC_ZERO + CHAR_W'(exp_dig);
            default:  sel_char = ASC_NUL;
        endcase
    end

    // Next-value logic for the operand registers
    always_comb
    begin
        mant_next      = mant_reg;
        e2_next        = e2_reg;
        neg_next       = neg_reg;
        zero_next      = zero_reg;
        nan_next       = nan_reg;
        frac_left_next = frac_left_reg;
        conv_cnt_next  = conv_cnt_reg;
        bcd_next       = bcd_reg;
        ed_cnt_next    = ed_cnt_reg;

        if (cmd.load)
        begin
            mant_next      = {(in_bexp != '0), in_frac};
            neg_next       = value_bits[63];
            zero_next      = (in_bexp == '0) && (in_frac == '0);
            nan_next       = (in_bexp == BEXP_SPECIAL);
            frac_left_next = (digit_count > MaxDig) ? MaxDig : digit_count;
            conv_cnt_next  = '0;
            bcd_next       = '0;
            if (in_bexp == '0)
            begin
                e2_next = (in_frac == '0) ? '0 : SUB_EXP;
            end
            else
            begin
                e2_next = {1'b0, in_bexp} - EXP_BIAS;
            end
        end

        if (cmd.norm_step)
        begin
            mant_next = {mant_reg[FRAC_W-1:0], 1'b0};
            e2_next   = e2_reg - 12'sd1;
        end

        if (cmd.conv_step)
        begin
            bcd_next      = {bcd_adj[BCD_W-2:0], mag_bit};
            conv_cnt_next = conv_cnt_reg + 4'd1;
        end

        // Digits past the fraction shift in as zero
        if (cmd.frac_step)
        begin
            mant_next      = {mant_reg[FRAC_W-4:0], 4'b0000};
            frac_left_next = frac_left_reg - 5'd1;
        end

        if (cmd.ed_init)
        begin
            ed_cnt_next = ed_lead;
        end
        else if (cmd.ed_step)
        begin
            ed_cnt_next = ed_cnt_reg - 2'd1;
        end
    end

    // Output register next value
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_nf_next    = out_nf_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = sel_char;
            out_last_next  = cmd.last;
            out_nf_next    = cmd.nf;
        end
        else if (char_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mant_reg      <= mant_next;
        e2_reg        <= e2_next;
        neg_reg       <= neg_next;
        zero_reg      <= zero_next;
        nan_reg       <= nan_next;
        frac_left_reg <= frac_left_next;
        bcd_reg       <= bcd_next;
        ed_cnt_reg    <= ed_cnt_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
        out_nf_reg    <= out_nf_next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            conv_cnt_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            conv_cnt_reg  <= conv_cnt_next;
        end
    end

    // Status back to the controller
    always_comb
    begin
        sts.nan       = nan_reg;
        sts.neg_show  = neg_reg && !zero_reg;
        sts.norm_done = mant_reg[FRAC_W] || zero_reg;
        sts.conv_last = (conv_cnt_reg == CONV_LAST);
        sts.frac_none = (frac_left_reg == '0);
        sts.frac_last = (frac_left_reg == 5'd1);
        sts.ed_zero   = (ed_cnt_reg == 2'd0);
        sts.out_free  = out_free;
    end

    assign char_valid = out_valid_reg;
    assign char_code  = out_char_reg;
    assign last_char  = out_last_reg;
    assign not_finite = out_nf_reg;

endmodule

/* sv/dthf_ctrl.sv */
// ----------------------------------------------------------------------------
// dthf_ctrl
// Controller: sequences decode, normalization, exponent conversion and the
// character stream, one character word per cycle when the output is free.
// ----------------------------------------------------------------------------
module dthf_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  dthf_pkg::sts_t sts,
    output dthf_pkg::cmd_t cmd
);
    import dthf_pkg::*;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: state_next = sts.nan ? ST_NAN : ST_NORM;
            ST_NORM:
            begin
                if (sts.norm_done)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (sts.conv_last)
                begin
                    state_next = sts.neg_show ? ST_MINUS : ST_ZERO;
                end
            end
            ST_MINUS: if (sts.out_free) state_next = ST_ZERO;
            ST_ZERO:  if (sts.out_free) state_next = ST_X;
            ST_X:     if (sts.out_free) state_next = ST_LEAD;
            ST_LEAD:  if (sts.out_free) state_next = ST_POINT;
            ST_POINT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.frac_none ? ST_P : ST_FRAC;
                end
            end
            ST_FRAC:
            begin
                if (sts.out_free && sts.frac_last)
                begin
                    state_next = ST_P;
                end
            end
            ST_P:     if (sts.out_free) state_next = ST_ESIGN;
            ST_ESIGN: if (sts.out_free) state_next = ST_EDIG;
            ST_EDIG:
            begin
                if (sts.out_free && sts.ed_zero)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_NAN:   if (sts.out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd        = '0;
        cmd.sel    = CH_NUL;
        item_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                cmd.load   = item_valid;
            end
            ST_DECODE: ;
            ST_NORM:   cmd.norm_step = !sts.norm_done;
            ST_CONV:   cmd.conv_step = 1'b1;
            ST_MINUS:
            begin
                cmd.emit = sts.out_free;
                cmd.sel  = CH_MINUS;
            end
            ST_ZERO:
            begin
                cmd.emit = sts.out_free;
                cmd.sel  = CH_ZERO;
            end
            ST_X:
            begin
                cmd.emit = sts.out_free;
                cmd.sel  = CH_X;
            end
            ST_LEAD:
            begin
                cmd.emit = sts.out_free;
                cmd.sel  = CH_LEAD;
            end
            ST_POINT:
            begin
                cmd.emit = sts.out_free;
                cmd.sel  = CH_POINT;
            end
            ST_FRAC:
            begin
                cmd.emit      = sts.out_free;
                cmd.frac_step = sts.out_free;
                cmd.sel       = CH_FRAC;
            end
            ST_P:
            begin
                cmd.emit = sts.out_free;
                cmd.sel  = CH_P;
            end
            ST_ESIGN:
            begin
                cmd.emit    = sts.out_free;
                cmd.ed_init = sts.out_free;
                cmd.sel     = CH_ESIGN;
            end
            ST_EDIG:
            begin
                cmd.emit    = sts.out_free;
                cmd.ed_step = sts.out_free;
                cmd.sel     = CH_EDIG;
                cmd.last    = sts.ed_zero;
            end
            ST_NAN:
            begin
                cmd.emit = sts.out_free;
                cmd.sel  = CH_NUL;
                cmd.last = 1'b1;
                cmd.nf   = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

/* sv/double_to_hex_float_text.sv */
// An accepted number is decoded; a subnormal is then shifted left in the
// one-bit-a-cycle normalizer until its leading one is at the top. The exponent
// BCD conversion follows; then one character per cycle while the output is free.
// A new number is accepted once the last character has reached the output register.
// Reset (rst_n, async, active low) returns the controller to idle with no output.
// ----------------------------------------------------------------------------
// double_to_hex_float_text
// Formats a finite binary64 bit pattern as [-]0x1.<hex digits>p<sign><exponent>
// text (0x0. for zero), one ASCII character word per output handshake.
// ----------------------------------------------------------------------------
module double_to_hex_float_text #(
    parameter int MAX_DIGITS = dthf_pkg::MAX_DIGITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [63:0]                   value_bits,
    input  logic [dthf_pkg::DCNT_W-1:0]   digit_count,
    output logic                          char_valid,
    input  logic                          char_ready,
    output logic [dthf_pkg::CHAR_W-1:0]   char_code,
    output logic                          last_char,
    output logic                          not_finite
);
    import dthf_pkg::*;

    cmd_t cmd;
    sts_t sts;

    dthf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    dthf_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .value_bits  (value_bits),
        .digit_count (digit_count),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .char_code   (char_code),
        .last_char   (last_char),
        .not_finite  (not_finite)
    );

endmodule

/* sv/dthf_chk.sv */
// ----------------------------------------------------------------------------
// dthf_chk
// Port-level checks for the hex float text formatter, bound to the top level.
// ----------------------------------------------------------------------------
module dthf_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_valid,
    input logic                          item_ready,
    input logic                          char_valid,
    input logic                          char_ready,
    input logic [dthf_pkg::CHAR_W-1:0]   char_code,
    input logic                          last_char,
    input logic                          not_finite
);

    // A non-finite input gives a single NUL word marked last
    a_nf_single: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && not_finite |-> last_char && (char_code == dthf_pkg::ASC_NUL))
        else $error("not_finite word is not a lone NUL");

    // Finite text never carries a NUL
    a_no_nul: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !not_finite |-> char_code != dthf_pkg::ASC_NUL)
        else $error("NUL character in finite text");

    // One number at a time: no accept in the cycle right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("input ready right after an accepted word");

    // A stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_ready |=> char_valid && $stable(char_code)
            && $stable(last_char) && $stable(not_finite))
        else $error("stalled output word changed");

endmodule

bind double_to_hex_float_text dthf_chk u_dthf_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_code  (char_code),
    .last_char  (last_char),
    .not_finite (not_finite)
);

/* bench/dthf_text_checker.sv */
// ----------------------------------------------------------------------------
// dthf_text_checker
// Watches the number and character channels of the hex float text formatter.
// Predicts the character words of every accepted number and compares each
// accepted character word with the oldest one still due. Reports a failure
// count and the number of character words still due.
// ----------------------------------------------------------------------------
module dthf_text_checker #(
    parameter int MAX_DIGITS = dthf_pkg::MAX_DIGITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  logic                        item_ready,
    input  logic [63:0]                 value_bits,
    input  logic [dthf_pkg::DCNT_W-1:0] digit_count,
    input  logic                        char_valid,
    input  logic                        char_ready,
    input  logic [dthf_pkg::CHAR_W-1:0] char_code,
    input  logic                        last_char,
    input  logic                        not_finite,
    output int                          fail_count,
    output int                          due_chars
);
    timeunit 1ns;
    timeprecision 1ps;

    import dthf_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
        logic              nf;
    } text_char_t;

    // Character words predicted but not yet seen, oldest first
    text_char_t pending_chars[$];
    text_char_t seen_char;
    text_char_t want_char;

    // Work out the full text of one number and queue its character words
    function automatic void format_hex_text(input logic [63:0] bits,
                                            input logic [DCNT_W-1:0] count);
        logic [CHAR_W-1:0] text[$];
        logic [BEXP_W-1:0] bexp;
        logic [FRAC_W-1:0] frac;
        logic              zero;
        logic [3:0]        nib;
        logic [3:0]        dec[4];
        int                ndig;
        int                e2;
        int                mag;
        int                top;
        int                n;
        bexp = bits[62:52];
        frac = bits[51:0];
        zero = 1'b0;
        e2   = 0;
        ndig = (int'(count) > MAX_DIGITS) ? MAX_DIGITS : int'(count);

        // Infinity and NaN: a lone flagged word
        if (bexp == BEXP_SPECIAL) begin
            pending_chars.push_back('{code: ASC_NUL, last: 1'b1, nf: 1'b1});
            return;
        end

        // Zero, or subnormal: shift the leading one out, exponent from its position
        if (bexp == '0) begin
            if (frac == '0) begin
                zero = 1'b1;
            end
            else begin
                top = FRAC_W - 1;
                while (!frac[top])
                    top--;
                e2   = top - 1074;
                frac = frac << (FRAC_W - top);
            end
        end
        else begin
            e2 = int'(bexp) - 1023;
        end

        // Sign and mantissa; negative zero prints unsigned
        if (bits[63] && !zero)
            text.push_back(ASC_MINUS);
        text.push_back(ASC_ZERO);
        text.push_back(ASC_X);
        text.push_back(zero ? ASC_ZERO : ASC_ONE);
        text.push_back(ASC_POINT);
        for (int i = 0; i < ndig; i++) begin
            nib = 4'h0;
            if (!zero && i < 13)
                nib = 4'(frac >> (48 - 4 * i));
            text.push_back(nib < 4'd10 ? ASC_ZERO + 7'(nib) : ASC_LOW_A + 7'(nib - 4'd10));
        end

        // Decimal exponent, no leading zeros
        text.push_back(ASC_P);
        text.push_back(e2 < 0 ? ASC_MINUS : ASC_PLUS);
        mag = (e2 < 0) ? -e2 : e2;
        n   = 0;
        do begin
            dec[n] = 4'(mag % 10);
            n++;
            mag /= 10;
        end while (mag > 0 && n < 4);
        while (n > 0) begin
            n--;
            text.push_back(ASC_ZERO + 7'(dec[n]));
        end

        foreach (text[k])
            pending_chars.push_back('{code: text[k], last: (k == text.size() - 1), nf: 1'b0});
    endfunction

    // Compare outgoing words first, then predict for an accepted number
    always @(posedge clk) begin
        if (!rst_n) begin
            pending_chars.delete();
            fail_count = 0;
            due_chars <= 0;
        end
        else begin
            if (char_valid && char_ready) begin
                seen_char = '{code: char_code, last: last_char, nf: not_finite};
                if (pending_chars.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected char word code %h last %b nf %b",
                                 $realtime, char_code, last_char, not_finite);
                end
                else begin
                    want_char = pending_chars.pop_front();
                    if (seen_char !== want_char) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: char word mismatch: ",
                                      "code %h/%h last %b/%b nf %b/%b (exp/act)"},
                                     $realtime, want_char.code, seen_char.code,
                                     want_char.last, seen_char.last,
                                     want_char.nf, seen_char.nf);
                    end
                end
            end
            if (item_valid && item_ready)
                format_hex_text(value_bits, digit_count);
            due_chars <= pending_chars.size();
        end
    end

endmodule

/* bench/double_to_hex_float_text_test.sv */
// ----------------------------------------------------------------------------
// double_to_hex_float_text_test
// Drives binary64 numbers with digit counts into the formatter: a directed
// set of edge values, then random numbers of every class. Both channels idle
// at random; the output side also holds off for a long stretch. A checker
// predicts and compares the character words.
// ----------------------------------------------------------------------------
module double_to_hex_float_text_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 80;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          item_valid;
    logic                          item_ready;
    logic [63:0]                   value_bits;
    logic [dthf_pkg::DCNT_W-1:0]   digit_count;
    logic                          char_valid;
    logic                          char_ready;
    logic [dthf_pkg::CHAR_W-1:0]   char_code;
    logic                          last_char;
    logic                          not_finite;
    int                            fail_count;
    int                            due_chars;

    // Set by the stimulus to ask the receiver for one long hold-off
    bit                            rx_hold_req = 1'b0;
    bit                            tx_calm = 1'b0;

    always #5 clk = ~clk;

    double_to_hex_float_text dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .value_bits  (value_bits),
        .digit_count (digit_count),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .char_code   (char_code),
        .last_char   (last_char),
        .not_finite  (not_finite)
    );

    dthf_text_checker watch (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .value_bits  (value_bits),
        .digit_count (digit_count),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .char_code   (char_code),
        .last_char   (last_char),
        .not_finite  (not_finite),
        .fail_count  (fail_count),
        .due_chars   (due_chars)
    );

    // Offer one number after a random gap; returns at the accepting edge
    task automatic send_number(input logic [63:0] bits,
                               input logic [dthf_pkg::DCNT_W-1:0] count);
        int gap;
        if ($urandom_range(0, 15) == 0)
            tx_calm = ~tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid  <= 1'b1;
        value_bits  <= bits;
        digit_count <= count;
        do @(posedge clk); while (!item_ready);
    endtask

    // Idle the input until every predicted word has come out
    task automatic wait_drained();
        item_valid <= 1'b0;
        do @(posedge clk); while (due_chars != 0);
    endtask

    // Receiver: random stall per word, calm stretches, one long hold-off
    initial begin
        int stall_left;
        bit rx_calm;
        bit hold_done;
        stall_left = 0;
        rx_calm    = 1'b0;
        hold_done  = 1'b0;
        char_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (char_ready && char_valid) begin
                if (last_char && $urandom_range(0, 7) == 0)
                    rx_calm = ~rx_calm;
                stall_left = rx_calm ? 0 : $urandom_range(0, 13);
                if (rx_hold_req && !hold_done) begin
                    stall_left = HOLD_CYCLES;
                    hold_done  = 1'b1;
                end
                if (stall_left > 0)
                    char_ready <= 1'b0;
            end
            else if (!char_ready) begin
                if (stall_left > 0)
                    stall_left--;
                if (stall_left == 0)
                    char_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    initial begin
        int cycles;
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Stimulus and verdict
    initial begin
        logic [63:0]                 rnd;
        logic [63:0]                 bits;
        logic [51:0]                 frac;
        logic [51:0]                 sub;
        logic [10:0]                 bexp;
        logic                        sign;
        logic [dthf_pkg::DCNT_W-1:0] count;
        int                          kind;

        rst_n       = 1'b0;
        item_valid  = 1'b0;
        value_bits  = '0;
        digit_count = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zeros, one, limits of normals and subnormals,
        // infinities and NaNs, saturated digit counts
        send_number(64'h0000000000000000, 5'd0);
        send_number(64'h8000000000000000, 5'd5);
        send_number(64'h3FF0000000000000, 5'd0);
        send_number(64'hBFF0000000000000, 5'd13);
        send_number(64'h7FEFFFFFFFFFFFFF, 5'd28);
        send_number(64'h0010000000000000, 5'd13);
        send_number(64'h0000000000000001, 5'd14);
        send_number(64'h800FFFFFFFFFFFFF, 5'd31);
        send_number(64'h0008000000000000, 5'd4);
        send_number(64'h7FF0000000000000, 5'd3);
        send_number(64'hFFF0000000000000, 5'd0);
        send_number(64'h7FF8000000000000, 5'd28);
        send_number(64'hFFFFFFFFFFFFFFFF, 5'd31);
        send_number(64'h7FF0000000000001, 5'd1);
        send_number(64'h3FB999999999999A, 5'd16);
        send_number(64'h4024000000000000, 5'd29);
        send_number(64'hC0C3880000000000, 5'd30);
        send_number(64'h3FE0000000000000, 5'd1);
        send_number(64'h4090000000000000, 5'd2);
        send_number(64'h3CB0000000000000, 5'd7);
        send_number(64'h7FE0000000000000, 5'd12);

        // Pause until the block is empty, then arm the long output hold-off
        wait_drained();
        rx_hold_req = 1'b1;

        // Random numbers of every class
        repeat (RANDOM_ITEMS) begin
            rnd  = {$urandom, $urandom};
            frac = rnd[51:0];
            sign = 1'($urandom_range(0, 1));
            kind = $urandom_range(0, 19);
            case (kind)
                0: bits = {sign, 63'd0};
                1: bits = {sign, 11'h7FF, ($urandom_range(0, 1) ? frac : 52'd0)};
                2, 3: begin
                    sub = frac >> $urandom_range(0, 51);
                    if (sub == '0)
                        sub = 52'd1;
                    bits = {sign, 11'd0, sub};
                end
                4: begin
                    case ($urandom_range(0, 3))
                        0: bexp = 11'd1;
                        1: bexp = 11'd2046;
                        2: bexp = 11'd1023;
                        default: bexp = 11'd1022;
                    endcase
                    bits = {sign, bexp, frac};
                end
                5, 6: bits = rnd;
                default: begin
                    bexp = 11'($urandom_range(1, 2046));
                    bits = {sign, bexp, frac};
                end
            endcase
            count = $urandom_range(0, 1) ? 5'($urandom_range(0, 31))
                                         : 5'($urandom_range(0, 8));
            send_number(bits, count);
        end

        // Drain and let any stray words show up
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* double_to_hex_float_text.f */
sv/dthf_pkg.sv
sv/dthf_dp.sv
sv/dthf_ctrl.sv
sv/double_to_hex_float_text.sv
sv/dthf_chk.sv
bench/dthf_text_checker.sv
bench/double_to_hex_float_text_test.sv
